// File: hw/rtl/windowed_encoder_value_bank_unit_macros.svh
// Assertion macros used by the checker file of the encoder value bank.
// Depends on nothing; include by bare file name.
`ifndef WINDOWED_ENCODER_VALUE_BANK_UNIT_MACROS_SVH
`define WINDOWED_ENCODER_VALUE_BANK_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define WEVB_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("wevb check failed");

// Next-cycle implication, disabled while reset is high.
`define WEVB_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("wevb check failed");

`endif

// File: hw/rtl/wevb_pkg.sv
// Shared constants and operation codes of the encoder value bank.
// Used by the top level, its port checker and the bench; depends on nothing.
package wevb_pkg;

  localparam int NUM_ENTRIES  = 128;
  localparam int ENTRY_W      = $clog2(NUM_ENTRIES);
  localparam int WINDOW_SLOTS = 8;
  localparam int VALUE_W      = 7;
  localparam int MASK_W       = 8;

  localparam logic [VALUE_W-1:0] MAX_VALUE  = 7'd127;
  localparam logic [ENTRY_W-1:0] OFFSET_MAX = ENTRY_W'(NUM_ENTRIES - 1 - WINDOW_SLOTS);
  localparam logic [7:0]         NOTE_STATUS = 8'h90;

  // Output word width (also used by the checker).
  localparam int OUT_W = 48;

  typedef enum logic [1:0] {
    OP_ENC  = 2'd0,
    OP_JOG  = 2'd1,
    OP_HOST = 2'd2,
    OP_READ = 2'd3
  } op_t;

endpackage

// File: hw/rtl/windowed_encoder_value_bank_unit.sv
// Top level of the windowed encoder value bank: value RAM, window offset,
// two-stage read-modify-write pipeline and output register.
// Depends on wevb_pkg.
//
// The block keeps 128 seven-bit controller values (all zero after reset) and
// a window offset that maps the eight encoder slots onto consecutive entries.
// Every input word is one operation, selected by s_tuser: an encoder turn
// adds a signed step to the slot's entry with clamping at 0..127 and emits a
// note event (0x90, entry, value) when the value moves; a jog turn shifts the
// window offset within 0..119 and, if it moves, asks for a refresh of all
// eight rings; a host set writes any entry; a read returns the value behind
// a slot. Each word yields exactly one result word. The block takes one word
// per clock while the output register is free or being emptied: the value
// RAM is read into a register at the accepting edge, and the add, clamp and
// write-back are done in the second stage, whose result lands in the output
// register when that register is free. A write in
// the second stage is forwarded to a read of the same entry issued in the
// same cycle. Entries never written read as zero through per-entry valid
// flops, so no clearing pass is needed after reset. The output register
// lets a new word enter while a finished result waits on m_tready.
module windowed_encoder_value_bank_unit
  import wevb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // [2:0] vpot_index, [9:3] increment, [16:10] entry_index, [23:17] host_value
  input  logic [23:0]       s_tdata,
  // [1:0] op
  input  logic [1:0]        s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // [0] changed, [1] send_valid, [9:2] event_status, [16:10] event_entry,
  // [23:17] event_value, [30:24] read_value, [37:31] window_offset,
  // [45:38] ring_update_mask, [47:46] zero
  output logic [OUT_W-1:0]  m_tdata
);

  // Input word fields.
  op_t                a_op;
  logic [2:0]         a_vpot;
  logic [6:0]         a_inc;
  logic [ENTRY_W-1:0] a_entry;
  logic [VALUE_W-1:0] a_host;
  logic               accept;

  assign a_op    = op_t'(s_tuser);
  assign a_vpot  = s_tdata[2:0];
  assign a_inc   = s_tdata[9:3];
  assign a_entry = s_tdata[16:10];
  assign a_host  = s_tdata[23:17];

  // Window offset, updated at acceptance so later words see it at once.
  logic [ENTRY_W-1:0] offset_reg;

  // Value RAM and its per-entry valid flops.
  logic [VALUE_W-1:0] mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] valid;

  // Second stage.
  logic               b_valid;
  op_t                b_op;
  logic [6:0]         b_inc;
  logic [VALUE_W-1:0] b_host;
  logic [ENTRY_W-1:0] b_addr;
  logic [ENTRY_W-1:0] b_off;
  logic               b_jog_chg;
  logic               fwd_hit;
  logic [VALUE_W-1:0] fwd_data;
  logic [VALUE_W-1:0] mem_q;
  logic               vld_q;
  logic               b_adv;

  // Stage-one address and jog arithmetic.
  logic [ENTRY_W-1:0]      a_addr;
  logic signed [ENTRY_W+1:0] jog_sum;
  logic [ENTRY_W-1:0]      jog_next;

  always_comb begin
    case (a_op)
      OP_HOST: a_addr = a_entry;
      default: a_addr = offset_reg + ENTRY_W'(a_vpot);
    endcase
    jog_sum = $signed({2'b00, offset_reg}) + $signed({{(ENTRY_W-5){a_inc[6]}}, a_inc});
    if (jog_sum < 0) begin
      jog_next = '0;
    end else if (jog_sum > $signed({2'b00, OFFSET_MAX})) begin
      jog_next = OFFSET_MAX;
    end else begin
      jog_next = jog_sum[ENTRY_W-1:0];
    end
  end

  // Stage-two compute.
  logic [VALUE_W-1:0]      prev;
  logic signed [VALUE_W+1:0] enc_sum;
  logic [VALUE_W-1:0]      enc_next;
  logic [VALUE_W-1:0]      host_val;
  logic [ENTRY_W-1:0]      rel;
  logic [MASK_W-1:0]       slot_mask;
  logic                    b_we;
  logic [VALUE_W-1:0]      b_wdata;
  logic                    o_changed;
  logic                    o_send;
  logic [7:0]              o_status;
  logic [ENTRY_W-1:0]      o_entry;
  logic [VALUE_W-1:0]      o_value;
  logic [VALUE_W-1:0]      o_read;
  logic [MASK_W-1:0]       o_mask;

  always_comb begin
    prev = fwd_hit ? fwd_data : (vld_q ? mem_q : '0);
    enc_sum = $signed({2'b00, prev}) + $signed({{2{b_inc[6]}}, b_inc});
    if (enc_sum < 0) begin
      enc_next = '0;
    end else if (enc_sum > $signed({2'b00, MAX_VALUE})) begin
      enc_next = MAX_VALUE;
    end else begin
      enc_next = enc_sum[VALUE_W-1:0];
    end
    host_val = (b_host > MAX_VALUE) ? MAX_VALUE : b_host;

    // Slot of the touched entry inside the window, if any.
    rel = b_addr - b_off;
    if (rel < ENTRY_W'(WINDOW_SLOTS) && rel < ENTRY_W'(MASK_W)) begin
      slot_mask = MASK_W'(1) << rel[2:0];
    end else begin
      slot_mask = '0;
    end

    b_we      = 1'b0;
    b_wdata   = enc_next;
    o_changed = 1'b0;
    o_send    = 1'b0;
    o_status  = '0;
    o_entry   = '0;
    o_value   = '0;
    o_read    = '0;
    o_mask    = '0;
    case (b_op)
      OP_ENC: begin
        o_read = enc_next;
        if (enc_next != prev) begin
          b_we      = 1'b1;
          o_changed = 1'b1;
          o_send    = 1'b1;
          o_status  = NOTE_STATUS;
          o_entry   = b_addr;
          o_value   = enc_next;
          o_mask    = slot_mask;
        end
      end
      OP_JOG: begin
        o_changed = b_jog_chg;
        o_mask    = b_jog_chg ? {MASK_W{1'b1}} : '0;
      end
      OP_HOST: begin
        b_we      = 1'b1;
        b_wdata   = host_val;
        o_changed = (prev != host_val);
        o_read    = host_val;
        o_mask    = slot_mask;
      end
      default: begin
        o_read = prev;
      end
    endcase
  end

  // Handshake: stage two drains into the output register when it is free.
  assign b_adv    = b_valid && (!m_tvalid || m_tready);
  assign s_tready = !b_valid || b_adv;
  assign accept   = s_tvalid && s_tready;

  // Control state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_reg <= '0;
      b_valid    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (accept && a_op == OP_JOG) begin
        offset_reg <= jog_next;
      end
      if (accept) begin
        b_valid <= 1'b1;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
      if (b_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Stage-two payload; forward a same-cycle write to the same entry.
  always_ff @(posedge clk) begin
    if (accept) begin
      b_op      <= a_op;
      b_inc     <= a_inc;
      b_host    <= a_host;
      b_addr    <= a_addr;
      b_off     <= (a_op == OP_JOG) ? jog_next : offset_reg;
      b_jog_chg <= (jog_next != offset_reg);
      fwd_hit   <= b_adv && b_we && (b_addr == a_addr);
      fwd_data  <= b_wdata;
    end
    if (b_adv) begin
      m_tdata <= {2'b00, o_mask, b_off, o_read, o_value, o_entry, o_status,
                  o_send, o_changed};
    end
  end

  // Value RAM: write-back from stage two, registered read at acceptance.
  always_ff @(posedge clk) begin
    if (b_adv && b_we) begin
      mem[b_addr] <= b_wdata;
    end
    if (accept) begin
      mem_q <= mem[a_addr];
    end
  end

  // Valid flops: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (b_adv && b_we) begin
        valid[b_addr] <= 1'b1;
      end
      if (accept) begin
        vld_q <= valid[a_addr];
      end
    end
  end

endmodule

// File: hw/rtl/wevb_checker.sv
// Port-level checker for the encoder value bank, bound to the top level.
// Depends on wevb_pkg and windowed_encoder_value_bank_unit_macros.svh.
`include "windowed_encoder_value_bank_unit_macros.svh"

module wevb_checker
  import wevb_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // Result fields watched by the event check.
  logic       ev_chg;
  logic       ev_sent;
  logic [7:0] ev_status;

  assign ev_chg    = m_tdata[0];
  assign ev_sent   = m_tdata[1];
  assign ev_status = m_tdata[9:2];

  // A stalled result holds.
  `WEVB_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // An event carries the note status and counts as a change.
  `WEVB_ASSERT_NOW(a_evt_status, clk, rst, m_tvalid && ev_sent, ev_status == NOTE_STATUS && ev_chg)
  // Without an event the event fields stay zero.
  `WEVB_ASSERT_NOW(a_evt_quiet, clk, rst, m_tvalid && !m_tdata[1], m_tdata[23:2] == 22'd0)
  // The window never runs past the bank.
  `WEVB_ASSERT_NOW(a_off_range, clk, rst, m_tvalid, m_tdata[37:31] <= OFFSET_MAX)

endmodule

bind windowed_encoder_value_bank_unit wevb_checker u_wevb_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: dv/windowed_encoder_value_bank_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for windowed_encoder_value_bank_unit: a directed table of words,
// then random words, each result checked against its typed row or an in-bench model of the value bank.
// Depends on wevb_pkg and the top level only.
module windowed_encoder_value_bank_unit_tb;
  import wevb_pkg::*;

  localparam int RANDOM_WORDS   = 800;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_CAP      = 60;
  localparam logic signed [6:0] STEP_MIN = 7'sh40;  // -64
  localparam logic signed [6:0] STEP_MAX = 7'sh3f;  // +63

  // Laid out exactly like m_tdata: first member lands in the top bits.
  typedef struct packed {
    logic [1:0]         pad;
    logic [MASK_W-1:0]  ring_mask;
    logic [ENTRY_W-1:0] offset;
    logic [VALUE_W-1:0] level;
    logic [VALUE_W-1:0] ev_value;
    logic [ENTRY_W-1:0] ev_entry;
    logic [7:0]         status;
    logic               sent;
    logic               changed;
  } bank_word_t;

  typedef struct {
    op_t                op;
    logic [2:0]         slot;
    logic signed [6:0]  step;
    logic [ENTRY_W-1:0] entry;
    logic [VALUE_W-1:0] level;
    bit                 typed;
    bank_word_t         want;
  } stim_row_t;

  localparam bank_word_t NO_WANT = '0;

  // Field boundaries of the result word, lowest field first.
  localparam int FIELD_LSB [9] = '{0, 1, 2, 10, 17, 24, 31, 38, 46};
  localparam int FIELD_W   [9] = '{1, 1, 8, 7, 7, 7, 7, 8, 2};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [23:0]       s_tdata = '0;
  logic [1:0]        s_tuser = OP_ENC;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  // Model state of the bank.
  logic [VALUE_W-1:0] bank_model [NUM_ENTRIES];
  logic [ENTRY_W-1:0] window_model;

  bank_word_t  expected_words [$];
  stim_row_t   directed_rows [25];
  bit          calm = 1'b0;  // both sides stop idling while set
  int          mismatches = 0;
  int          results_seen = 0;
  int          note_events = 0;
  int          op_count [4] = '{0, 0, 0, 0};
  int          idle_cycles = 0;

  windowed_encoder_value_bank_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [2:0] slot, [9:3] step, [16:10] entry, [23:17] level
    .s_tuser  (s_tuser),   // [1:0] op
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // see bank_word_t for the field layout
  );

  initial forever #2 clk = ~clk;

  function automatic int clamp_to(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Ring bit of an entry, relative to the current window; none outside it.
  function automatic logic [MASK_W-1:0] ring_bit(logic [ENTRY_W-1:0] entry);
    logic [ENTRY_W-1:0] rel;
    rel = entry - window_model;
    if (int'(rel) < WINDOW_SLOTS && int'(rel) < MASK_W) return MASK_W'(1) << rel;
    return '0;
  endfunction

  // Apply one word to the bank model and return the result it should give.
  function automatic bank_word_t bank_apply(op_t op, logic [2:0] slot,
                                            logic signed [6:0] step,
                                            logic [ENTRY_W-1:0] entry,
                                            logic [VALUE_W-1:0] level_in);
    bank_word_t         w;
    logic [ENTRY_W-1:0] idx;
    logic [VALUE_W-1:0] lvl;
    int                 target;
    w = '0;
    idx = window_model + ENTRY_W'(slot);
    case (op)
      OP_ENC: begin
        // Plain add, then clamp; a negative step simply bottoms out at zero.
        target = clamp_to(int'(bank_model[idx]) + int'(step), int'(MAX_VALUE));
        if (target != int'(bank_model[idx])) begin
          bank_model[idx] = VALUE_W'(target);
          w.changed   = 1'b1;
          w.sent      = 1'b1;
          w.status    = NOTE_STATUS;
          w.ev_entry  = idx;
          w.ev_value  = VALUE_W'(target);
          w.ring_mask = ring_bit(idx);
        end
        w.level = VALUE_W'(target);
      end
      OP_JOG: begin
        target = clamp_to(int'(window_model) + int'(step), int'(OFFSET_MAX));
        if (target != int'(window_model)) begin
          window_model = ENTRY_W'(target);
          w.changed    = 1'b1;
          w.ring_mask  = {MASK_W{1'b1}};
        end
      end
      OP_HOST: begin
        lvl = (level_in > MAX_VALUE) ? MAX_VALUE : level_in;
        w.changed = (bank_model[entry] != lvl);
        bank_model[entry] = lvl;
        w.level = lvl;
        // Ring request follows the window, not whether the value moved.
        w.ring_mask = ring_bit(entry);
      end
      default: begin
        w.level = bank_model[idx];
      end
    endcase
    w.offset = window_model;
    return w;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] result %0d: %s: got 0x%0h, want 0x%0h",
               $time, results_seen, what, got, want);
  endtask

  // Present one word, hold it until taken, then log what it should produce.
  task automatic drive_word(op_t op, logic [2:0] slot, logic signed [6:0] step,
                            logic [ENTRY_W-1:0] entry, logic [VALUE_W-1:0] level,
                            bit typed, bank_word_t want);
    bank_word_t predicted;
    // Idle before the word; valid drops only when a gap is taken.
    if (!calm && $urandom_range(0, 99) < 27) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(0, 99) < 27);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {level, entry, step, slot};
    do @(posedge clk); while (!s_tready);
    predicted = bank_apply(op, slot, step, entry, level);
    expected_words.push_back(typed ? want : predicted);
    op_count[int'(op)]++;
  endtask

  // Result side: check each accepted word, then draw the next stall.
  always @(posedge clk) begin : result_check
    bank_word_t       want;
    logic [OUT_W-1:0] fmask;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing expected", m_tdata, 0);
      end else begin
        want = expected_words.pop_front();
        for (int k = 0; k < 9; k++) begin
          fmask = (OUT_W'(1) << FIELD_W[k]) - OUT_W'(1);
          if (((m_tdata >> FIELD_LSB[k]) & fmask) != ((want >> FIELD_LSB[k]) & fmask))
            report_mismatch($sformatf("bits [%0d:%0d]", FIELD_LSB[k] + FIELD_W[k] - 1,
                                      FIELD_LSB[k]),
                            (m_tdata >> FIELD_LSB[k]) & fmask,
                            (want >> FIELD_LSB[k]) & fmask);
        end
        if (want.sent) note_events++;
      end
      results_seen++;
    end
    m_tready <= calm || ($urandom_range(0, 99) >= 27);
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    op_t                op;
    logic [2:0]         slot;
    logic signed [6:0]  step;
    logic [ENTRY_W-1:0] entry;
    logic [VALUE_W-1:0] level;
    int                 pick;
    int                 typed_rows;

    foreach (bank_model[i]) bank_model[i] = '0;
    window_model = '0;
    typed_rows = 0;

    // want order: pad, ring_mask, offset, level, ev_value, ev_entry, status, sent, changed
    directed_rows = '{
      // read after reset: everything zero
      '{OP_READ, 3'd0, 7'sd0, 7'd0, 7'd0, 1'b1,
        '{2'd0, 8'h00, 7'd0, 7'd0, 7'd0, 7'd0, 8'h00, 1'b0, 1'b0}},
      // largest negative step on a zero entry: clamps at zero, no event
      '{OP_ENC, 3'd0, STEP_MIN, 7'd0, 7'd0, 1'b1,
        '{2'd0, 8'h00, 7'd0, 7'd0, 7'd0, 7'd0, 8'h00, 1'b0, 1'b0}},
      '{OP_ENC, 3'd7, STEP_MAX, 7'd0, 7'd0, 1'b1,
        '{2'd0, 8'h80, 7'd0, 7'd63, 7'd63, 7'd7, NOTE_STATUS, 1'b1, 1'b1}},
      '{OP_ENC, 3'd7, STEP_MAX, 7'd0, 7'd0, 1'b1,
        '{2'd0, 8'h80, 7'd0, 7'd126, 7'd126, 7'd7, NOTE_STATUS, 1'b1, 1'b1}},
      // top clamp
      '{OP_ENC, 3'd7, STEP_MAX, 7'd0, 7'd0, 1'b1,
        '{2'd0, 8'h80, 7'd0, 7'd127, 7'd127, 7'd7, NOTE_STATUS, 1'b1, 1'b1}},
      // already at the top: unchanged, no event, no ring
      '{OP_ENC, 3'd7, 7'sd1, 7'd0, 7'd0, 1'b1,
        '{2'd0, 8'h00, 7'd0, 7'd127, 7'd0, 7'd0, 8'h00, 1'b0, 1'b0}},
      '{OP_ENC, 3'd7, STEP_MIN, 7'd0, 7'd0, 1'b1,
        '{2'd0, 8'h80, 7'd0, 7'd63, 7'd63, 7'd7, NOTE_STATUS, 1'b1, 1'b1}},
      // jog below zero: offset unchanged
      '{OP_JOG, 3'd0, STEP_MIN, 7'd0, 7'd0, 1'b1,
        '{2'd0, 8'h00, 7'd0, 7'd0, 7'd0, 7'd0, 8'h00, 1'b0, 1'b0}},
      '{OP_JOG, 3'd0, STEP_MAX, 7'd0, 7'd0, 1'b1,
        '{2'd0, 8'hff, 7'd63, 7'd0, 7'd0, 7'd0, 8'h00, 1'b0, 1'b1}},
      // jog past the top of the range
      '{OP_JOG, 3'd0, STEP_MAX, 7'd0, 7'd0, 1'b1,
        '{2'd0, 8'hff, 7'd119, 7'd0, 7'd0, 7'd0, 8'h00, 1'b0, 1'b1}},
      '{OP_JOG, 3'd0, 7'sd1, 7'd0, 7'd0, 1'b1,
        '{2'd0, 8'h00, 7'd119, 7'd0, 7'd0, 7'd0, 8'h00, 1'b0, 1'b0}},
      // last slot of the highest window: entry 126
      '{OP_ENC, 3'd7, 7'sd5, 7'd0, 7'd0, 1'b1,
        '{2'd0, 8'h80, 7'd119, 7'd5, 7'd5, 7'd126, NOTE_STATUS, 1'b1, 1'b1}},
      '{OP_READ, 3'd7, 7'sd0, 7'd0, 7'd0, 1'b0, NO_WANT},
      // host set just past the window: no ring bit
      '{OP_HOST, 3'd0, 7'sd0, 7'd127, 7'd127, 1'b1,
        '{2'd0, 8'h00, 7'd119, 7'd127, 7'd0, 7'd0, 8'h00, 1'b0, 1'b1}},
      // host set inside the window with the same value: ring bit, no change
      '{OP_HOST, 3'd0, 7'sd0, 7'd120, 7'd0, 1'b1,
        '{2'd0, 8'h02, 7'd119, 7'd0, 7'd0, 7'd0, 8'h00, 1'b0, 1'b0}},
      '{OP_HOST, 3'd0, 7'sd0, 7'd0, 7'd127, 1'b1,
        '{2'd0, 8'h00, 7'd119, 7'd127, 7'd0, 7'd0, 8'h00, 1'b0, 1'b1}},
      '{OP_READ, 3'd0, 7'sd0, 7'd0, 7'd0, 1'b0, NO_WANT},
      '{OP_JOG, 3'd0, STEP_MIN, 7'd0, 7'd0, 1'b0, NO_WANT},
      '{OP_JOG, 3'd0, STEP_MIN, 7'd0, 7'd0, 1'b0, NO_WANT},
      '{OP_READ, 3'd0, 7'sd0, 7'd0, 7'd0, 1'b0, NO_WANT},
      '{OP_ENC, 3'd0, -7'sd1, 7'd0, 7'd0, 1'b0, NO_WANT},
      '{OP_HOST, 3'd0, 7'sd0, 7'd3, 7'h55, 1'b0, NO_WANT},
      '{OP_READ, 3'd3, 7'sd0, 7'd0, 7'd0, 1'b0, NO_WANT},
      '{OP_ENC, 3'd3, STEP_MIN, 7'd0, 7'd0, 1'b0, NO_WANT},
      '{OP_HOST, 3'd0, 7'sd0, 7'd7, 7'd63, 1'b0, NO_WANT}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed) typed_rows++;
      drive_word(directed_rows[i].op, directed_rows[i].slot, directed_rows[i].step,
                 directed_rows[i].entry, directed_rows[i].level,
                 directed_rows[i].typed, directed_rows[i].want);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // Hold both sides busy through one long stretch in the middle.
      calm = (n >= 300 && n < 420);
      pick = $urandom_range(0, 99);
      op = (pick < 50) ? OP_ENC : (pick < 60) ? OP_JOG : (pick < 80) ? OP_HOST : OP_READ;
      slot  = 3'($urandom);
      entry = ENTRY_W'($urandom);
      level = VALUE_W'($urandom);
      // Mostly small turns as a hand gives them, sometimes a full-range step.
      if ($urandom_range(0, 9) < 7)
        step = 7'(int'($urandom_range(0, 8)) - 4);
      else
        step = 7'($urandom);
      if (op == OP_HOST) begin
        if ($urandom_range(0, 9) < 4) entry = window_model + ENTRY_W'($urandom_range(0, 7));
        if ($urandom_range(0, 4) == 0) level = bank_model[entry];
      end
      drive_word(op, slot, step, entry, level, 1'b0, NO_WANT);
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    // Drain outstanding results, then let the pipeline idle before the report.
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d words (%0d typed rows): %0d encoder, %0d jog, %0d host set, %0d read",
             op_count[0] + op_count[1] + op_count[2] + op_count[3], typed_rows,
             op_count[int'(OP_ENC)], op_count[int'(OP_JOG)], op_count[int'(OP_HOST)],
             op_count[int'(OP_READ)]);
    $display("compared %0d result words, %0d carried note events, %0d field mismatches",
             results_seen, note_events, mismatches);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
